// File: rtl/pcw_pkg.sv
// pcw_pkg: shared types, register indexes and output codes for the power cycle watchdog
// no dependencies; used by every file of the block
`timescale 1ns / 1ps
`default_nettype none

package pcw_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_OFF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_GRACE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AUTO       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW         = 3'd5;

  // register reset values
  localparam logic [31:0] RST_CHECK_INTERVAL = 32'd60000;
  localparam logic [7:0]  RST_FAIL_THRESHOLD = 8'd5;
  localparam logic [31:0] RST_POWER_OFF      = 32'd20000;
  localparam logic [31:0] RST_BOOT_GRACE     = 32'd300000;
  localparam logic [7:0]  RST_MAX_AUTO       = 8'd3;
  localparam logic [31:0] RST_WINDOW         = 32'd7200000;

  // phase codes as seen on the result beat
  localparam logic [1:0] PHASE_MON   = 2'd0;
  localparam logic [1:0] PHASE_CUT   = 2'd1;
  localparam logic [1:0] PHASE_GRACE = 2'd2;

  // cycle start codes
  localparam logic [1:0] START_NONE   = 2'd0;
  localparam logic [1:0] START_MANUAL = 2'd1;
  localparam logic [1:0] START_AUTO   = 2'd2;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    MODE_MON   = 3'b001,
    MODE_CUT   = 3'b010,
    MODE_GRACE = 3'b100
  } mode_t;

  typedef struct packed {
    logic [31:0] check_period_ms;
    logic [7:0]  failure_threshold;
    logic [31:0] power_off_ms;
    logic [31:0] boot_grace_ms;
    logic [7:0]  max_auto_cycles;
    logic [31:0] window_ms;
  } cfg_t;

  typedef struct packed {
    logic [63:0] now_ms;
    logic        manual_request;
    logic        link_ok;
  } item_t;

  // packed msb first, so reconnect_pulse lands in the top bit of tdata
  typedef struct packed {
    logic       reconnect_pulse;
    logic       limit_hit;
    logic [1:0] cycle_started;
    logic       check_taken;
    logic [7:0] auto_cycles;
    logic [7:0] fail_count;
    logic [1:0] phase;
    logic       modem_power;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/pcw_cfg.sv
// pcw_cfg: configuration register bank of the power cycle watchdog
// depends on pcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcw_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [pcw_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [31:0]                    wr_data,
  output pcw_pkg::cfg_t                       cfg
);

  pcw_pkg::cfg_t cfg_r;
  pcw_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        pcw_pkg::REG_CHECK_INTERVAL: cfg_nxt.check_period_ms   = wr_data;
        pcw_pkg::REG_FAIL_THRESHOLD: cfg_nxt.failure_threshold = wr_data[7:0];
        pcw_pkg::REG_POWER_OFF:      cfg_nxt.power_off_ms      = wr_data;
        pcw_pkg::REG_BOOT_GRACE:     cfg_nxt.boot_grace_ms     = wr_data;
        pcw_pkg::REG_MAX_AUTO:       cfg_nxt.max_auto_cycles   = wr_data[7:0];
        pcw_pkg::REG_WINDOW:         cfg_nxt.window_ms         = wr_data;
        default: ; // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_period_ms   <= pcw_pkg::RST_CHECK_INTERVAL;
      cfg_r.failure_threshold <= pcw_pkg::RST_FAIL_THRESHOLD;
      cfg_r.power_off_ms      <= pcw_pkg::RST_POWER_OFF;
      cfg_r.boot_grace_ms     <= pcw_pkg::RST_BOOT_GRACE;
      cfg_r.max_auto_cycles   <= pcw_pkg::RST_MAX_AUTO;
      cfg_r.window_ms         <= pcw_pkg::RST_WINDOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/pcw_core.sv
// pcw_core: watchdog state registers and single-pass next-state logic
// depends on pcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcw_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire pcw_pkg::item_t  item,
  input  wire pcw_pkg::cfg_t   cfg,
  output pcw_pkg::result_t     res
);

  pcw_pkg::mode_t mode_r, mode_nxt;
  logic [63:0] phase_start_r, phase_start_nxt;
  logic [63:0] last_check_r, last_check_nxt;
  logic [63:0] window_start_r, window_start_nxt;
  logic [7:0]  fail_r, fail_nxt;
  logic [7:0]  auto_r, auto_nxt;
  logic        started_r;

  logic [63:0] el_phase, el_check, el_window;
  logic        first, man_go, cut_done, grace_done, due, win_ref;
  logic        trip, lim, auto_go;
  pcw_pkg::mode_t mode_a, mode_b;
  logic [7:0]  fail_a, fail_inc, auto_a;

  // three independent wrapping elapsed times
  assign el_phase  = item.now_ms - phase_start_r;
  assign el_check  = item.now_ms - last_check_r;
  assign el_window = item.now_ms - window_start_r;

  always_comb begin
    first  = !started_r;
    man_go = item.manual_request && (mode_r == pcw_pkg::MODE_MON);
    mode_a = man_go ? pcw_pkg::MODE_CUT : mode_r;

    // a cut started this step has zero elapsed time
    cut_done   = (mode_a == pcw_pkg::MODE_CUT) &&
                 (man_go ? (cfg.power_off_ms == 32'd0)
                         : (el_phase >= {32'd0, cfg.power_off_ms}));
    grace_done = (mode_r == pcw_pkg::MODE_GRACE) &&
                 (el_phase >= {32'd0, cfg.boot_grace_ms});

    if (cut_done)        mode_b = pcw_pkg::MODE_GRACE;
    else if (grace_done) mode_b = pcw_pkg::MODE_MON;
    else                 mode_b = mode_a;

    // last check time is now on the first item and when grace ends
    due = (mode_b == pcw_pkg::MODE_MON) &&
          ((first || grace_done) ? (cfg.check_period_ms == 32'd0)
                                 : (el_check >= {32'd0, cfg.check_period_ms}));
    win_ref = first ? (cfg.window_ms == 32'd0) : (el_window >= {32'd0, cfg.window_ms});

    fail_a   = (man_go || grace_done) ? 8'd0 : fail_r;
    auto_a   = (due && win_ref) ? 8'd0 : auto_r;
    fail_inc = (fail_a == 8'hFF) ? fail_a : fail_a + 8'd1;

    trip    = due && !item.link_ok && (fail_inc >= cfg.failure_threshold);
    lim     = trip && (auto_a >= cfg.max_auto_cycles);
    auto_go = trip && !lim;

    mode_nxt = auto_go ? pcw_pkg::MODE_CUT : mode_b;
    if (!due)                      fail_nxt = fail_a;
    else if (item.link_ok || auto_go) fail_nxt = 8'd0;
    else                           fail_nxt = fail_inc;
    auto_nxt = auto_go ? auto_a + 8'd1 : auto_a;

    phase_start_nxt  = (man_go || cut_done || auto_go) ? item.now_ms : phase_start_r;
    last_check_nxt   = (first || grace_done || due) ? item.now_ms : last_check_r;
    window_start_nxt = (first || (due && win_ref)) ? item.now_ms : window_start_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= pcw_pkg::MODE_MON;
      phase_start_r  <= '0;
      last_check_r   <= '0;
      window_start_r <= '0;
      fail_r         <= '0;
      auto_r         <= '0;
      started_r      <= 1'b0;
    end else if (step) begin
      mode_r         <= mode_nxt;
      phase_start_r  <= phase_start_nxt;
      last_check_r   <= last_check_nxt;
      window_start_r <= window_start_nxt;
      fail_r         <= fail_nxt;
      auto_r         <= auto_nxt;
      started_r      <= 1'b1;
    end
  end

  always_comb begin
    unique case (mode_nxt)
      pcw_pkg::MODE_CUT:   res.phase = pcw_pkg::PHASE_CUT;
      pcw_pkg::MODE_GRACE: res.phase = pcw_pkg::PHASE_GRACE;
      default:             res.phase = pcw_pkg::PHASE_MON;
    endcase
    res.modem_power     = (mode_nxt != pcw_pkg::MODE_CUT);
    res.fail_count      = fail_nxt;
    res.auto_cycles     = auto_nxt;
    res.check_taken     = due;
    res.limit_hit       = lim;
    res.reconnect_pulse = grace_done;
    if (man_go)       res.cycle_started = pcw_pkg::START_MANUAL;
    else if (auto_go) res.cycle_started = pcw_pkg::START_AUTO;
    else              res.cycle_started = pcw_pkg::START_NONE;
  end

endmodule

`default_nettype wire

// File: rtl/power_cycle_watchdog_top.sv
// power_cycle_watchdog_top: modem power cycle watchdog, streaming top level
// path: input beat to result beat through the input register, then the result register
// throughput: one item per cycle while out_tready is high, limited by the single-pass state update in pcw_core
// reset: rst_n synchronous, active low; clears the valid bits of both stages, the state and the config bank
// config writes are taken every cycle (cfg_ready tied high)
// depends on pcw_pkg, pcw_cfg, pcw_core
`timescale 1ns / 1ps
`default_nettype none

module power_cycle_watchdog_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // from bit 0: now_ms[63:0], manual_request, link_ok, zero fill
  input  wire logic [pcw_pkg::IN_DATA_W-1:0]       in_tdata,
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // from bit 0: modem_power, phase[1:0], fail_count[7:0], auto_cycles[7:0],
  // check_taken, cycle_started[1:0], limit_hit, reconnect_pulse
  output logic [pcw_pkg::OUT_DATA_W-1:0]           out_tdata,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [31:0]                         cfg_data
);

  pcw_pkg::cfg_t    cfg;
  pcw_pkg::item_t   item_r;
  pcw_pkg::result_t res;
  pcw_pkg::result_t res_r;

  logic item_v_r;
  logic res_v_r;
  logic step;      // item in the input register moves to the result register
  logic in_fire;

  // the result register frees up when empty or its beat is being taken
  assign step      = item_v_r && (!res_v_r || out_tready);
  assign in_tready = !item_v_r || step;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  pcw_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.now_ms         <= in_tdata[63:0];
      item_r.manual_request <= in_tdata[64];
      item_r.link_ok        <= in_tdata[65];
    end
  end

  pcw_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (step) begin
      res_v_r <= 1'b1;
    end else if (out_tready) begin
      res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_v_r;
  assign out_tdata  = res_r;

endmodule

`default_nettype wire

// File: rtl/pcw_checker.sv
// pcw_checker: port-level assertions for the power cycle watchdog
// depends on power_cycle_watchdog_top (bound below) and pcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcw_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [pcw_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // relay drive follows the phase
  a_power_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[0] == (out_tdata[2:1] != pcw_pkg::PHASE_CUT))
    else $error("modem_power disagrees with phase");

  // a started cycle never leaves the block monitoring
  a_start_leaves_mon: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[21:20] != pcw_pkg::START_NONE)
      |-> out_tdata[2:1] != pcw_pkg::PHASE_MON)
    else $error("cycle started but phase is monitoring");

  // a refused cycle only comes from a check taken while monitoring
  a_limit_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22] |-> out_tdata[19] && (out_tdata[2:1] == pcw_pkg::PHASE_MON))
    else $error("limit hit without a check in monitoring");

  // nothing leaves straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_tvalid)
    else $error("result beat right after reset");

endmodule

bind power_cycle_watchdog_top pcw_checker u_pcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
